// ===== design/paf_pkg.sv =====
// Package for the piecewise adhesion pair force block.
// Holds the field widths, the register index codes and the default parameter values.
// No dependencies.
package paf_pkg;

  localparam int SEP_W = 24;
  localparam int RAD_W = 16;
  localparam int AGE_W = 16;
  localparam int WORD_W = 16;
  localparam int FORCE_W = 32;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_TYPES_DEF = 2;
  localparam int SQ_W = 48;
  localparam int DIST_W = SQ_W / 2;
  localparam int MAG_W = 32;
  localparam int IN_DATA_W = 112;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STIFF    = 3'd0,
    CFG_ATTR     = 3'd1,
    CFG_WELL     = 3'd2,
    CFG_FADE     = 3'd3,
    CFG_BOUNDARY = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [AGE_W-1:0] a1;
    logic [AGE_W-1:0] f1;
    logic [AGE_W-1:0] a2;
    logic [AGE_W-1:0] f2;
  } fade_t;

endpackage

// ===== design/piecewise_adhesion_pair_force_top.sv =====
// Top level of the piecewise adhesion pair force block.
// Depends on paf_pkg, paf_isqrt and paf_div.
//
// One particle pair enters on the s_axis channel per transaction and one force result
// leaves on the m_axis channel per transaction, in order. The pair's types travel in
// s_axis_tuser; everything else in s_axis_tdata.
// The configuration registers are written through wr_en, wr_index and wr_data. The user
// must write them only while no transaction is in flight; the block does not enforce it.
// From an accepted input transaction to m_axis_tvalid, a pair passes three input stages,
// the 24-stage square root, five coefficient stages, then three 32-stage dividers (by
// distance, then by each fade age) with a multiply stage before the last two, and the
// saturation and output registers.
// Throughput is one pair per cycle while the skid register is empty; every stage before
// the output register is a register stage moving on a common enable.
// Reset clears the valid bits of all stages and the output and skid registers, and sets
// the registers to their reset values.
// When the receiver stalls, one more result is caught in a skid register; the pipeline and
// s_axis_tready then hold until the output is taken. Nothing is lost or repeated.
module piecewise_adhesion_pair_force_top #(
  parameter int NUM_TYPES = paf_pkg::NUM_TYPES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sep_x, sep_y, radius_first, radius_second, age_first, age_second
  input  logic [paf_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // type_first, type_second
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // force_x, force_y, in_contact, zero fill
  output logic [paf_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  logic                                wr_en,
  input  logic [paf_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [paf_pkg::CFG_W-1:0]           wr_data
);

  typedef struct packed {
    logic signed [23:0] sx;
    logic signed [23:0] sy;
    logic [16:0]        b;
    logic [15:0]        k;
    logic [15:0]        e;
    logic [33:0]        t1;
    logic [34:0]        t2;
    logic [50:0]        tw;
    logic [48:0]        kbe;
    paf_pkg::fade_t     fade;
  } sq_side_t;

  typedef struct packed {
    logic           neg;
    logic           contact;
    paf_pkg::fade_t fade;
  } lane_side_t;

  localparam int SQ_SW = $bits(sq_side_t);
  localparam int LN_SW = $bits(lane_side_t);

  // Registers.
  logic [63:0] stiff;
  logic [63:0] attr;
  logic [31:0] well;
  logic [15:0] fade_age;
  logic        bnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiff    <= '0;
      attr     <= '0;
      well     <= '0;
      fade_age <= 16'd1;
      bnd      <= 1'b1;
    end else if (wr_en) begin
      case (wr_index)
        paf_pkg::CFG_STIFF:    stiff    <= wr_data;
        paf_pkg::CFG_ATTR:     attr     <= wr_data;
        paf_pkg::CFG_WELL:     well     <= wr_data[31:0];
        paf_pkg::CFG_FADE:     fade_age <= wr_data[15:0];
        paf_pkg::CFG_BOUNDARY: bnd      <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Flow control.
  logic en;
  logic skid_valid;
  assign en = ~skid_valid;
  assign s_axis_tready = en;

  // Input field decode.
  logic signed [23:0] in_sx, in_sy;
  logic [15:0]        in_ri, in_rj, in_agei, in_agej;
  logic               ti, tj, apply, fade1, fade2;
  logic [1:0]         tbl_n;
  paf_pkg::fade_t     in_fade;

  assign in_sx   = $signed(s_axis_tdata[23:0]);
  assign in_sy   = $signed(s_axis_tdata[47:24]);
  assign in_ri   = s_axis_tdata[63:48];
  assign in_rj   = s_axis_tdata[79:64];
  assign in_agei = s_axis_tdata[95:80];
  assign in_agej = s_axis_tdata[111:96];
  assign ti = (int'(s_axis_tuser[0]) >= NUM_TYPES) ? 1'(NUM_TYPES - 1) : s_axis_tuser[0];
  assign tj = (int'(s_axis_tuser[1]) >= NUM_TYPES) ? 1'(NUM_TYPES - 1) : s_axis_tuser[1];
  assign tbl_n = 2'(int'(ti) * NUM_TYPES + int'(tj));
  assign apply = (tj != bnd);
  assign fade1 = apply && (in_agei < fade_age);
  assign fade2 = apply && (in_agej < fade_age);
  assign in_fade.a1 = fade1 ? in_agei : 16'd1;
  assign in_fade.f1 = fade1 ? fade_age : 16'd1;
  assign in_fade.a2 = fade2 ? in_agej : 16'd1;
  assign in_fade.f2 = fade2 ? fade_age : 16'd1;

  // Stage 0: operand selection.
  logic               v0;
  logic signed [23:0] s0_sx, s0_sy;
  logic [23:0]        s0_ax, s0_ay;
  logic [16:0]        s0_b;
  logic [15:0]        s0_k, s0_e, s0_w;
  paf_pkg::fade_t     s0_fade;

  // Stage 1: squares and table products.
  logic               v1;
  logic signed [23:0] s1_sx, s1_sy;
  logic [47:0]        s1_ax2, s1_ay2;
  logic [31:0]        s1_ke;
  logic [32:0]        s1_ew;
  logic [16:0]        s1_b;
  logic [15:0]        s1_k, s1_e;
  paf_pkg::fade_t     s1_fade;

  // Stage 2: squared distance and thresholds.
  logic        v2;
  logic [47:0] s2_v;
  sq_side_t    s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_sx   <= in_sx;
      s0_sy   <= in_sy;
      s0_ax   <= in_sx[23] ? 24'(-in_sx) : 24'(in_sx);
      s0_ay   <= in_sy[23] ? 24'(-in_sy) : 24'(in_sy);
      s0_b    <= {1'b0, in_ri} + {1'b0, in_rj};
      s0_k    <= stiff[{tbl_n, 4'b0} +: 16];
      s0_e    <= attr[{tbl_n, 4'b0} +: 16];
      s0_w    <= well[{ti, 4'b0} +: 16];
      s0_fade <= in_fade;

      s1_sx   <= s0_sx;
      s1_sy   <= s0_sy;
      s1_ax2  <= s0_ax * s0_ax;
      s1_ay2  <= s0_ay * s0_ay;
      s1_ke   <= s0_k * s0_e;
      s1_ew   <= s0_e * (17'd4096 + 17'(s0_w));
      s1_b    <= s0_b;
      s1_k    <= s0_k;
      s1_e    <= s0_e;
      s1_fade <= s0_fade;

      s2_v         <= s1_ax2 + s1_ay2;
      s2_side.sx   <= s1_sx;
      s2_side.sy   <= s1_sy;
      s2_side.b    <= s1_b;
      s2_side.k    <= s1_k;
      s2_side.e    <= s1_e;
      s2_side.t1   <= s1_b * (17'd65536 + 17'(s1_e));
      s2_side.t2   <= s1_b * (18'd65536 + {1'b0, s1_e, 1'b0});
      s2_side.tw   <= s1_b * (34'd268435456 + 34'(s1_ew));
      s2_side.kbe  <= s1_ke * s1_b;
      s2_side.fade <= s1_fade;
    end
  end

  // Distance.
  logic                 q_valid;
  logic [23:0]          q_d;
  logic [SQ_SW-1:0]     q_side_vec;
  sq_side_t             q_side;

  paf_isqrt #(
    .VW(paf_pkg::SQ_W),
    .SW(SQ_SW)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .in_val   (s2_v),
    .in_side  (s2_side),
    .out_valid(q_valid),
    .out_root (q_d),
    .out_side (q_side_vec)
  );

  assign q_side = sq_side_t'(q_side_vec);

  // Stage C1: branch tests and spring product.
  logic signed [25:0] diff;
  logic signed [42:0] kdb;
  logic [39:0]        d28;
  logic [51:0]        d40;

  assign diff = $signed({2'b0, q_d}) - $signed({9'b0, q_side.b});
  assign kdb  = $signed({1'b0, q_side.k}) * diff;
  assign d28  = {q_d, 16'b0};
  assign d40  = {q_d, 28'b0};

  logic               c1v, c2v, c3v, c4v;
  logic               c1_le1, c1_le2, c1_lt2, c1_gw;
  logic signed [42:0] c1_kdb;
  logic [23:0]        c1_d;
  logic signed [23:0] c1_sx, c1_sy, c2_sx, c2_sy, c3_sx, c3_sy;
  logic [15:0]        c1_e;
  logic [48:0]        c1_kbe;
  paf_pkg::fade_t     c1_fade, c2_fade, c3_fade, c4_fade;
  logic               c2_lt2, c3_lt2, c4_lt2;
  logic [23:0]        c2_d, c3_d, c4_d;
  logic signed [59:0] c2_c36;
  logic signed [33:0] c3_c12;

  // Stage C2: coefficient in Q.36.
  logic signed [59:0] sp, rev, pull, c36_sel;
  assign sp   = 60'($signed({c1_kdb, 16'b0}));
  assign rev  = $signed({10'b0, c1_kbe, 1'b0}) - sp;
  assign pull = $signed({24'b0, c1_e, 20'b0});

  always_comb begin
    if (c1_le1) begin
      c36_sel = sp;
    end else if (c1_gw) begin
      c36_sel = pull;
    end else if (c1_le2) begin
      c36_sel = rev;
    end else begin
      c36_sel = '0;
    end
  end

  // Stage C3: truncation toward zero to Q.12.
  logic signed [59:0] c36_adj;
  assign c36_adj = c2_c36 + $signed({36'b0, {24{c2_c36[59]}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      c1v <= 1'b0;
      c2v <= 1'b0;
      c3v <= 1'b0;
      c4v <= 1'b0;
    end else if (en) begin
      c1v <= q_valid;
      c2v <= c1v;
      c3v <= c2v;
      c4v <= c3v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_le1  <= d28 <= 40'(q_side.t1);
      c1_le2  <= d28 <= 40'(q_side.t2);
      c1_lt2  <= d28 < 40'(q_side.t2);
      c1_gw   <= d40 > 52'(q_side.tw);
      c1_kdb  <= kdb;
      c1_d    <= q_d;
      c1_sx   <= q_side.sx;
      c1_sy   <= q_side.sy;
      c1_e    <= q_side.e;
      c1_kbe  <= q_side.kbe;
      c1_fade <= q_side.fade;

      c2_c36  <= c36_sel;
      c2_lt2  <= c1_lt2;
      c2_d    <= c1_d;
      c2_sx   <= c1_sx;
      c2_sy   <= c1_sy;
      c2_fade <= c1_fade;

      c3_c12  <= $signed(c36_adj[57:24]);
      c3_lt2  <= c2_lt2;
      c3_d    <= c2_d;
      c3_sx   <= c2_sx;
      c3_sy   <= c2_sy;
      c3_fade <= c2_fade;

      c4_lt2  <= c3_lt2;
      c4_d    <= c3_d;
      c4_fade <= c3_fade;
    end
  end

  // Per-component lanes: product, division by distance, two fade-in scalings, saturation.
  logic [31:0] lane_force   [2];
  logic        lane_vld     [2];
  logic        lane_contact [2];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [23:0] sep;
    logic signed [57:0] c4_p;
    logic               c5v;
    logic [54:0]        c5_num;
    logic [23:0]        c5_den;
    lane_side_t         c5_side;
    logic               d1v, d2v, d3v, m1v, m2v, sv;
    logic [31:0]        q1, q2, q3;
    logic [LN_SW-1:0]   sd1, sd2, sd3;
    lane_side_t         ls1, ls2, ls3;
    logic [47:0]        m1, m2;
    lane_side_t         m1_side, m2_side;
    logic [31:0]        fsat;
    logic               fcontact;

    assign sep = (l == 0) ? c3_sx : c3_sy;

    always_ff @(posedge clk) begin
      if (rst) begin
        c5v <= 1'b0;
        m1v <= 1'b0;
        m2v <= 1'b0;
        sv  <= 1'b0;
      end else if (en) begin
        c5v <= c4v;
        m1v <= d1v;
        m2v <= d2v;
        sv  <= d3v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c4_p            <= c3_c12 * sep;
        c5_num          <= c4_p[57] ? 55'(-c4_p) : 55'(c4_p);
        c5_den          <= (c4_d == '0) ? 24'd1 : c4_d;
        c5_side.neg     <= c4_p[57];
        c5_side.contact <= c4_lt2;
        c5_side.fade    <= c4_fade;

        m1      <= q1 * ls1.fade.a1;
        m1_side <= ls1;
        m2      <= q2 * ls2.fade.a2;
        m2_side <= ls2;

        fcontact <= ls3.contact;
        if (!ls3.neg) begin
          fsat <= q3[31] ? 32'h7FFF_FFFF : q3;
        end else begin
          fsat <= (q3 > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q3);
        end
      end
    end

    paf_div #(.NW(55), .DW(24), .QW(paf_pkg::MAG_W), .SW(LN_SW)) u_div_dist (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(c5v), .in_num(c5_num), .in_den(c5_den), .in_side(c5_side),
      .out_valid(d1v), .out_quo(q1), .out_side(sd1)
    );
    assign ls1 = lane_side_t'(sd1);

    paf_div #(.NW(48), .DW(paf_pkg::AGE_W), .QW(paf_pkg::MAG_W), .SW(LN_SW)) u_div_fade1 (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(m1v), .in_num(m1), .in_den(m1_side.fade.f1), .in_side(m1_side),
      .out_valid(d2v), .out_quo(q2), .out_side(sd2)
    );
    assign ls2 = lane_side_t'(sd2);

    paf_div #(.NW(48), .DW(paf_pkg::AGE_W), .QW(paf_pkg::MAG_W), .SW(LN_SW)) u_div_fade2 (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(m2v), .in_num(m2), .in_den(m2_side.fade.f2), .in_side(m2_side),
      .out_valid(d3v), .out_quo(q3), .out_side(sd3)
    );
    assign ls3 = lane_side_t'(sd3);

    assign lane_force[l]   = fsat;
    assign lane_vld[l]     = sv;
    assign lane_contact[l] = fcontact;
  end

  // Output register with one skid entry.
  logic        p_valid;
  logic [64:0] p_data;
  logic        out_valid;
  logic [64:0] out_data;
  logic [64:0] skid_data;
  logic        take;

  assign p_valid = lane_vld[0] & lane_vld[1];
  assign p_data  = {lane_contact[0], lane_force[1], lane_force[0]};
  assign take    = out_valid & m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (p_valid) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (p_valid) begin
      if (!out_valid || take) begin
        out_data <= p_data;
      end else begin
        skid_data <= p_data;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_data};

endmodule

// ===== design/paf_isqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Carries a side vector alongside each stage. Depends on paf_pkg.
module paf_isqrt #(
  parameter int VW = paf_pkg::SQ_W,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [VW-1:0]     in_val,
  input  logic [SW-1:0]     in_side,
  output logic              out_valid,
  output logic [VW/2-1:0]   out_root,
  output logic [SW-1:0]     out_side
);

  localparam int RTW = VW / 2;
  localparam int RMW = RTW + 2;

  logic            vld  [1:RTW];
  logic [VW-1:0]   val  [1:RTW];
  logic [RMW-1:0]  rem  [1:RTW];
  logic [RTW-1:0]  root [1:RTW];
  logic [SW-1:0]   side [1:RTW];

  for (genvar s = 0; s < RTW; s++) begin : g_stage
    logic            src_vld;
    logic [VW-1:0]   src_val;
    logic [RMW-1:0]  src_rem;
    logic [RTW-1:0]  src_root;
    logic [SW-1:0]   src_side;
    logic [RMW-1:0]  tmp;
    logic [RMW-1:0]  trial;

    if (s == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_val  = in_val;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_side = in_side;
    end else begin : g_rest
      assign src_vld  = vld[s];
      assign src_val  = val[s];
      assign src_rem  = rem[s];
      assign src_root = root[s];
      assign src_side = side[s];
    end

    assign tmp   = {src_rem[RMW-3:0], src_val[2*(RTW-1-s)+1 -: 2]};
    assign trial = {src_root, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val[s+1]  <= src_val;
        side[s+1] <= src_side;
        if (tmp >= trial) begin
          rem[s+1]  <= tmp - trial;
          root[s+1] <= {src_root[RTW-2:0], 1'b1};
        end else begin
          rem[s+1]  <= tmp;
          root[s+1] <= {src_root[RTW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[RTW];
  assign out_root  = root[RTW];
  assign out_side  = side[RTW];

endmodule

// ===== design/paf_div.sv =====
// Pipelined restoring divider for unsigned operands, one quotient bit per stage.
// The quotient must fit in QW bits. Depends on paf_pkg.
module paf_div #(
  parameter int NW = paf_pkg::SQ_W,
  parameter int DW = paf_pkg::AGE_W,
  parameter int QW = paf_pkg::MAG_W,
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [NW-1:0]  in_num,
  input  logic [DW-1:0]  in_den,
  input  logic [SW-1:0]  in_side,
  output logic           out_valid,
  output logic [QW-1:0]  out_quo,
  output logic [SW-1:0]  out_side
);

  localparam int RW = DW + QW;

  logic           vld  [1:QW];
  logic [RW-1:0]  rem  [1:QW];
  logic [QW-1:0]  quo  [1:QW];
  logic [DW-1:0]  den  [1:QW];
  logic [SW-1:0]  side [1:QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic           src_vld;
    logic [RW-1:0]  src_rem;
    logic [QW-1:0]  src_quo;
    logic [DW-1:0]  src_den;
    logic [SW-1:0]  src_side;
    logic [RW-1:0]  shifted;

    if (s == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_rem  = RW'(in_num);
      assign src_quo  = '0;
      assign src_den  = in_den;
      assign src_side = in_side;
    end else begin : g_rest
      assign src_vld  = vld[s];
      assign src_rem  = rem[s];
      assign src_quo  = quo[s];
      assign src_den  = den[s];
      assign src_side = side[s];
    end

    assign shifted = RW'(src_den) << (QW - 1 - s);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den[s+1]  <= src_den;
        side[s+1] <= src_side;
        if (src_rem >= shifted) begin
          rem[s+1] <= src_rem - shifted;
          quo[s+1] <= {src_quo[QW-2:0], 1'b1};
        end else begin
          rem[s+1] <= src_rem;
          quo[s+1] <= {src_quo[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_quo   = quo[QW];
  assign out_side  = side[QW];

endmodule

// ===== tb/tb_piecewise_adhesion_pair_force_top.sv =====
// Self-checking testbench for piecewise_adhesion_pair_force_top.
// Drives particle pairs with random idle and stall gaps and compares every result with an
// internal force predictor. Depends on paf_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_piecewise_adhesion_pair_force_top;

  localparam int LATENCY = 132;
  localparam int SETTLE = LATENCY + 10;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [paf_pkg::AGE_W-1:0] age_second;
    logic [paf_pkg::AGE_W-1:0] age_first;
    logic [paf_pkg::RAD_W-1:0] radius_second;
    logic [paf_pkg::RAD_W-1:0] radius_first;
    logic [paf_pkg::SEP_W-1:0] sep_y;
    logic [paf_pkg::SEP_W-1:0] sep_x;
  } pair_t;

  typedef struct packed {
    logic in_contact;
    logic [paf_pkg::FORCE_W-1:0] force_y;
    logic [paf_pkg::FORCE_W-1:0] force_x;
  } force_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [paf_pkg::IN_DATA_W-1:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [paf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic wr_en;
  logic [paf_pkg::CFG_IDX_W-1:0] wr_index;
  logic [paf_pkg::CFG_W-1:0] wr_data;

  logic [63:0] stiff_words;
  logic [63:0] attr_words;
  logic [31:0] well_words;
  logic [15:0] fade_len;
  logic boundary_kind;

  force_t expected_forces[$];
  int errors;
  int rx_wait;
  bit steady;
  longint cycles;

  piecewise_adhesion_pair_force_top u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint floor_sqrt(longint v);
    longint r;
    r = 0;
    for (int i = 25; i >= 0; i--) begin
      if ((r + (longint'(1) << i)) * (r + (longint'(1) << i)) <= v) r = r + (longint'(1) << i);
    end
    return r;
  endfunction

  function automatic longint fade_by(longint f, longint age);
    if (age < longint'(fade_len)) f = f * age / longint'(fade_len);
    return f;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic force_t predict_pair(pair_t p, logic kind_first, logic kind_second);
    longint sx, sy, b, k, e, w, d, d28, c36, c12, fx, fy;
    int n;
    logic le_eps, le_2eps, lt_2eps, gt_well;
    force_t r;
    sx = longint'($signed(p.sep_x));
    sy = longint'($signed(p.sep_y));
    b = longint'(p.radius_first) + longint'(p.radius_second);
    n = int'(kind_first) * 2 + int'(kind_second);
    k = longint'(stiff_words[16*n +: 16]);
    e = longint'(attr_words[16*n +: 16]);
    w = longint'(well_words[16*int'(kind_first) +: 16]);
    d = floor_sqrt(sx * sx + sy * sy);
    d28 = d << 16;
    le_eps = d28 <= b * (65536 + e);
    le_2eps = d28 <= b * (65536 + 2 * e);
    lt_2eps = d28 < b * (65536 + 2 * e);
    gt_well = (d << 28) > b * ((longint'(1) << 28) + e * (4096 + w));
    c36 = 0;
    if (le_eps) c36 = k * ((d - b) * 65536);
    else if (gt_well) c36 = e << 20;
    else if (le_2eps) c36 = -(k * (d28 - (b << 16) - 2 * b * e));
    c12 = c36 / (longint'(1) << 24);
    fx = 0;
    fy = 0;
    if (d != 0) begin
      fx = c12 * sx / d;
      fy = c12 * sy / d;
    end
    if (kind_second != boundary_kind) begin
      fx = fade_by(fade_by(fx, longint'(p.age_first)), longint'(p.age_second));
      fy = fade_by(fade_by(fy, longint'(p.age_first)), longint'(p.age_second));
    end
    r.force_x = clip32(fx);
    r.force_y = clip32(fy);
    r.in_contact = lt_2eps;
    return r;
  endfunction

  task automatic send_pair(pair_t p, logic kind_first, logic kind_second);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= p;
    s_axis_tuser <= {kind_second, kind_first};
    do @(posedge clk); while (!s_axis_tready);
    expected_forces.push_back(predict_pair(p, kind_first, kind_second));
  endtask

  task automatic write_reg(paf_pkg::cfg_index_t idx, logic [63:0] value);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      paf_pkg::CFG_STIFF: stiff_words = value;
      paf_pkg::CFG_ATTR: attr_words = value;
      paf_pkg::CFG_WELL: well_words = value[31:0];
      paf_pkg::CFG_FADE: fade_len = value[15:0];
      paf_pkg::CFG_BOUNDARY: boundary_kind = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Builds a pair whose distance lands near the contact distance so that every force
  // branch is reached; a quarter of the pairs are fully random noise.
  task automatic send_shaped_pair();
    pair_t p;
    logic k1, k2;
    longint b, e, m, d, sx, sy;
    int n;
    p = pair_t'(112'({$urandom(), $urandom(), $urandom(), $urandom()}));
    k1 = 1'($urandom_range(0, 1));
    k2 = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 9) != 0) begin
        p.radius_first = 16'($urandom_range(0, 16'h3000));
        p.radius_second = 16'($urandom_range(1, 16'h3000));
      end else if (p.radius_second == 0) begin
        p.radius_second = 16'd1;
      end
      b = longint'(p.radius_first) + longint'(p.radius_second);
      n = int'(k1) * 2 + int'(k2);
      e = longint'(attr_words[16*n +: 16]);
      m = 65536 - 16384 + longint'($urandom_range(0, 16384 + 2048 + 3 * int'(e)));
      d = (b * m) >> 16;
      sx = longint'($urandom_range(0, int'(d)));
      sy = floor_sqrt(d * d - sx * sx);
      if ($urandom_range(0, 1)) sx = -sx;
      if ($urandom_range(0, 1)) sy = -sy;
      p.sep_x = sx[23:0];
      p.sep_y = sy[23:0];
      if ($urandom_range(0, 1)) begin
        p.age_first = 16'($urandom_range(0, 2 * int'(fade_len) + 2));
        p.age_second = 16'($urandom_range(0, 2 * int'(fade_len) + 2));
      end
    end else if (p.radius_second == 0) begin
      p.radius_second = 16'd1;
    end
    send_pair(p, k1, k2);
  endtask

  task automatic run_shaped(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0) steady = ~steady;
      send_shaped_pair();
    end
    steady = 1'b0;
  endtask

  task automatic test_reset_defaults();
    pair_t p;
    p = '0;
    p.sep_x = 24'h001000;
    p.radius_first = 16'h0800;
    p.radius_second = 16'h0800;
    send_pair(p, 1'b0, 1'b0);
    send_pair(p, 1'b1, 1'b1);
    drain_pipeline();
  endtask

  task automatic test_field_extremes();
    pair_t p;
    write_reg(paf_pkg::CFG_STIFF, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(paf_pkg::CFG_ATTR, 64'hFFFF_8000_2000_0100);
    write_reg(paf_pkg::CFG_WELL, 64'h0000_0000_FFFF_1000);
    write_reg(paf_pkg::CFG_FADE, 64'd100);
    write_reg(paf_pkg::CFG_BOUNDARY, 64'd0);
    p = '0;
    p.radius_second = 16'h0001;
    send_pair(p, 1'b0, 1'b0);
    p.radius_first = 16'hFFFF;
    p.radius_second = 16'hFFFF;
    send_pair(p, 1'b0, 1'b1);
    for (int t = 0; t < 4; t++) begin
      p.sep_x = 24'h7FFFFF;
      p.sep_y = 24'h7FFFFF;
      p.radius_first = 16'h0000;
      p.radius_second = 16'h0001;
      p.age_first = 16'hFFFF;
      p.age_second = 16'hFFFF;
      send_pair(p, t[1], t[0]);
      p.sep_x = 24'h800000;
      p.sep_y = 24'h800000;
      p.age_first = 16'h0000;
      p.age_second = 16'd50;
      send_pair(p, t[1], t[0]);
      p.sep_x = 24'h000000;
      p.sep_y = 24'hFFF000;
      p.radius_first = 16'h0800;
      p.radius_second = 16'h0800;
      p.age_first = 16'd99;
      p.age_second = 16'd100;
      send_pair(p, t[1], t[0]);
      p.sep_x = 24'hFFF000;
      p.sep_y = 24'h000000;
      p.radius_first = 16'hFFFF;
      p.radius_second = 16'hFFFF;
      send_pair(p, t[1], t[0]);
    end
    drain_pipeline();
  endtask

  task automatic test_branch_shapes();
    write_reg(paf_pkg::CFG_STIFF, 64'h0400_0100_0080_2000);
    write_reg(paf_pkg::CFG_ATTR, 64'h4000_1000_2000_0800);
    write_reg(paf_pkg::CFG_WELL, 64'h0000_0000_0800_3000);
    write_reg(paf_pkg::CFG_FADE, 64'd40);
    write_reg(paf_pkg::CFG_BOUNDARY, 64'd1);
    run_shaped(140);
    drain_pipeline();
    write_reg(paf_pkg::CFG_STIFF, rand64());
    write_reg(paf_pkg::CFG_ATTR, rand64());
    write_reg(paf_pkg::CFG_WELL, rand64());
    write_reg(paf_pkg::CFG_FADE, {48'd0, 16'($urandom_range(1, 65535))});
    run_shaped(120);
    drain_pipeline();
  endtask

  task automatic test_fade_and_boundary();
    write_reg(paf_pkg::CFG_FADE, 64'd0);
    write_reg(paf_pkg::CFG_BOUNDARY, 64'd0);
    run_shaped(100);
    drain_pipeline();
    write_reg(paf_pkg::CFG_FADE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(paf_pkg::CFG_BOUNDARY, 64'hFFFF_FFFF_FFFF_FFFE);
    run_shaped(100);
    drain_pipeline();
    write_reg(paf_pkg::CFG_FADE, 64'd1);
    write_reg(paf_pkg::CFG_BOUNDARY, 64'd1);
    write_reg(paf_pkg::CFG_ATTR, 64'h0000_0000_0000_0000);
    write_reg(paf_pkg::CFG_WELL, 64'd0);
    run_shaped(60);
    drain_pipeline();
  endtask

  task automatic test_unused_indexes();
    write_reg(paf_pkg::CFG_STIFF, 64'h1234_0800_0100_FFFF);
    write_reg(paf_pkg::CFG_ATTR, 64'h3000_0400_FFFF_1800);
    write_reg(paf_pkg::CFG_WELL, 64'h0000_0000_0000_FFFF);
    write_reg(paf_pkg::CFG_FADE, 64'd16);
    write_reg(paf_pkg::cfg_index_t'(3'd5), rand64());
    write_reg(paf_pkg::cfg_index_t'(3'd6), rand64());
    write_reg(paf_pkg::cfg_index_t'(3'd7), rand64());
    run_shaped(180);
    drain_pipeline();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_forces.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          errors++;
        end else begin
          force_t want;
          force_t got;
          want = expected_forces.pop_front();
          got = m_axis_tdata[64:0];
          if (got.force_x !== want.force_x) begin
            $display("%0t: force_x expected %h actual %h", $time, want.force_x, got.force_x);
            errors++;
          end
          if (got.force_y !== want.force_y) begin
            $display("%0t: force_y expected %h actual %h", $time, want.force_y, got.force_y);
            errors++;
          end
          if (got.in_contact !== want.in_contact) begin
            $display("%0t: in_contact expected %b actual %b", $time, want.in_contact,
                     got.in_contact);
            errors++;
          end
        end
        rx_wait = steady ? 0 : $urandom_range(0, 17);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      m_axis_tready <= (rx_wait == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_piecewise_adhesion_pair_force_top: done, errors");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    steady = 1'b0;
    stiff_words = '0;
    attr_words = '0;
    well_words = '0;
    fade_len = 16'd1;
    boundary_kind = 1'b1;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_field_extremes();
    test_branch_shapes();
    test_fade_and_boundary();
    test_unused_indexes();
    if (expected_forces.size() != 0) errors++;
    if (errors == 0) begin
      $display("tb_piecewise_adhesion_pair_force_top: done, clean");
    end else begin
      $display("tb_piecewise_adhesion_pair_force_top: done, errors");
    end
    $finish;
  end

endmodule
